[sv/ppmd_pkg.sv]
// ppmd_pkg: shared types and constants of the ppm pulse train decoder
package ppmd_pkg;

  // configuration register map, one 32-bit word each
  typedef enum logic [1:0] {
    REG_GAIN   = 2'd0,
    REG_OFFSET = 2'd1,
    REG_GAP    = 2'd2,
    REG_CHLIM  = 2'd3
  } ppmd_reg_t;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned GAIN_W   = 10;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned GAP_W    = 16;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned VALUE_W  = 16;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 10'd244;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd1220;
  localparam logic [GAP_W-1:0]    GAP_RESET    = 16'd4000;
  localparam logic [INDEX_W-1:0]  CHLIM_RESET  = 4'd9;
  localparam logic [INDEX_W-1:0]  INDEX_MAX    = 4'd15;

  // a channel pulse time never exceeds the 16-bit gap limit
  localparam int unsigned TIME_W = GAP_W;
  localparam int unsigned PROD_W = TIME_W + GAIN_W;

  // divide by 100: q = (x * ceil(2^33 / 100)) >> 33, exact for x < 2^26
  localparam int unsigned RECIP_W     = 27;
  localparam int unsigned RECIP_SHIFT = 33;
  localparam logic [RECIP_W-1:0] RECIP = 27'd85899346;
  localparam int unsigned WIDE_W = PROD_W + RECIP_W;
  localparam int unsigned QUO_W  = WIDE_W - RECIP_SHIFT;

  localparam logic [QUO_W-1:0] POS_LIMIT = 20'd32767;
  localparam logic [QUO_W-1:0] NEG_LIMIT = 20'd32768;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 16'h7FFF;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 16'h8000;

  // payload of a channel item through the scaling stages
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               neg;
  } ppmd_tag_t;

endpackage

[sv/ppm_pulse_train_decoder.sv]
// ppm_pulse_train_decoder: ppm tick decoder with pipelined channel scaling
// scaling runs in a multiply pipeline of registers s1, s2, s3 and out after a pin
// sample is accepted; throughput: one pin sample per cycle, set by the edge
// detector and counter update done in the accept cycle, unless out_ready stalls the pipeline
// reset (rst_n, synchronous) clears counter, level, channel index and pipeline
// valids, and loads the configuration registers with their defaults
module ppm_pulse_train_decoder
  import ppmd_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_pin_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [INDEX_W-1:0]    out_channel_index,
  output logic signed [VALUE_W-1:0] out_channel_value,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned CMP_W = (COUNTER_WIDTH > GAP_W) ? COUNTER_WIDTH : GAP_W;

  // configuration
  logic [GAIN_W-1:0]   gain_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [GAP_W-1:0]    gap_r;
  logic [INDEX_W-1:0]  chlim_r;
  logic                cfg_wr;
  ppmd_reg_t           cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = ppmd_reg_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      offset_r <= OFFSET_RESET;
      gap_r    <= GAP_RESET;
      chlim_r  <= CHLIM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_GAIN:   gain_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_OFFSET: offset_r <= cfg_pwdata[OFFSET_W-1:0];
        REG_GAP:    gap_r    <= cfg_pwdata[GAP_W-1:0];
        REG_CHLIM:  chlim_r  <= cfg_pwdata[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_GAIN:   cfg_prdata = CFG_DATA_W'(gain_r);
      REG_OFFSET: cfg_prdata = CFG_DATA_W'(offset_r);
      REG_GAP:    cfg_prdata = CFG_DATA_W'(gap_r);
      REG_CHLIM:  cfg_prdata = CFG_DATA_W'(chlim_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // edge detection and frame state
  logic                     last_level_r;
  logic [COUNTER_WIDTH-1:0] tick_count_r, tick_count_nxt;
  logic [INDEX_W-1:0]       next_channel_r, next_channel_nxt;
  logic                     in_fire, rising, falling, time_ok, emit;
  logic [CMP_W-1:0]         time_ext, gap_ext;
  logic [TIME_W-1:0]        time16, off16, mag_diff;
  logic                     diff_neg;

  assign in_fire  = in_valid && in_ready;
  assign rising   = in_pin_level && !last_level_r;
  assign falling  = !in_pin_level && last_level_r;
  assign time_ext = CMP_W'(tick_count_r);
  assign gap_ext  = CMP_W'(gap_r);
  assign time_ok  = time_ext <= gap_ext;
  assign emit     = in_fire && rising && time_ok && (next_channel_r < chlim_r);

  assign time16   = time_ext[TIME_W-1:0];
  assign off16    = TIME_W'(offset_r);
  assign diff_neg = time16 < off16;
  assign mag_diff = diff_neg ? (off16 - time16) : (time16 - off16);

  always_comb begin
    tick_count_nxt   = tick_count_r;
    next_channel_nxt = next_channel_r;
    if (falling) begin
      tick_count_nxt = '0;
    end else if (tick_count_r != '1) begin
      tick_count_nxt = tick_count_r + 1'b1;
    end
    if (rising) begin
      if (!time_ok) begin
        next_channel_nxt = '0;
      end else if (next_channel_r < INDEX_MAX) begin
        next_channel_nxt = next_channel_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r   <= 1'b0;
      tick_count_r   <= '0;
      next_channel_r <= '0;
    end else if (in_fire) begin
      last_level_r   <= in_pin_level;
      tick_count_r   <= tick_count_nxt;
      next_channel_r <= next_channel_nxt;
    end
  end

  // scaling pipeline: |diff| -> |diff|*gain -> /100 -> saturate
  logic              s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic              s1_free, s2_free, s3_free, out_free;
  ppmd_tag_t         s1_tag_r, s2_tag_r, s3_tag_r;
  logic [TIME_W-1:0] s1_mag_r;
  logic [PROD_W-1:0] s2_prod_r;
  logic [WIDE_W-1:0] wide;
  logic [QUO_W-1:0]  s3_quo_r;
  logic [VALUE_W-1:0] sat_value;
  logic [INDEX_W-1:0] out_index_r;
  logic [VALUE_W-1:0] out_value_r;

  assign out_free = !out_v_r || out_ready;
  assign s3_free  = !s3_v_r || out_free;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free;

  assign wide = WIDE_W'(s2_prod_r) * WIDE_W'(RECIP);

  always_comb begin
    if (s3_tag_r.neg) begin
      sat_value = (s3_quo_r > NEG_LIMIT) ? VALUE_MIN : (~s3_quo_r[VALUE_W-1:0] + 1'b1);
    end else begin
      sat_value = (s3_quo_r > POS_LIMIT) ? VALUE_MAX : s3_quo_r[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_free)  s1_v_r  <= emit;
      if (s2_free)  s2_v_r  <= s1_v_r;
      if (s3_free)  s3_v_r  <= s2_v_r;
      if (out_free) out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_tag_r.index <= next_channel_r;
      s1_tag_r.neg   <= diff_neg;
      s1_mag_r       <= mag_diff;
    end
    if (s2_free) begin
      s2_tag_r  <= s1_tag_r;
      s2_prod_r <= PROD_W'(s1_mag_r) * PROD_W'(gain_r);
    end
    if (s3_free) begin
      s3_tag_r <= s2_tag_r;
      s3_quo_r <= wide[WIDE_W-1:RECIP_SHIFT];
    end
    if (out_free) begin
      out_index_r <= s3_tag_r.index;
      out_value_r <= sat_value;
    end
  end

  assign out_valid         = out_v_r;
  assign out_channel_index = out_index_r;
  assign out_channel_value = signed'(out_value_r);

  // a falling edge restarts the pulse timer
  a_fall_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && falling |=> tick_count_r == '0)
    else $error("tick counter not cleared on falling edge");

  // a sync gap restarts the frame
  a_sync_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && rising && !time_ok |=> next_channel_r == '0)
    else $error("channel index not reset on sync gap");

  // a channel pulse never moves the index backwards
  a_index_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && rising && time_ok |=> next_channel_r >= $past(next_channel_r))
    else $error("channel index decreased on a channel pulse");

  // saturation keeps a non-negative offset-corrected time non-negative
  a_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_free && s3_v_r && !s3_tag_r.neg |=> !out_value_r[VALUE_W-1])
    else $error("positive channel value came out negative");

endmodule

[sim/ppm_pulse_train_decoder_test.sv]
`timescale 1ns / 100ps
// ppm_pulse_train_decoder_test: self-checking testbench of the ppm pulse train decoder
module ppm_pulse_train_decoder_test;
  import ppmd_pkg::*;

  localparam int unsigned CNT_W        = 16;
  localparam logic [CNT_W-1:0] TICK_MAX = {CNT_W{1'b1}};
  localparam int          SCALE_DIV    = 100;
  localparam int unsigned IDLE_PCT     = 32;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned PULSE_CAP    = 40;

  typedef struct {
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
  } chan_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_pin_level = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [INDEX_W-1:0]        out_channel_index;
  logic signed [VALUE_W-1:0] out_channel_value;
  logic                      cfg_psel = 1'b0;
  logic                      cfg_penable = 1'b0;
  logic                      cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]     cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]     cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]     cfg_prdata;
  logic                      cfg_pready;

  // predicted decoder state and settings
  logic [GAIN_W-1:0]   gain_set   = GAIN_RESET;
  logic [OFFSET_W-1:0] offset_set = OFFSET_RESET;
  logic [GAP_W-1:0]    gap_set    = GAP_RESET;
  logic [INDEX_W-1:0]  chlim_set  = CHLIM_RESET;
  logic                prev_level = 1'b0;
  logic [CNT_W-1:0]    tick_count = '0;
  logic [INDEX_W-1:0]  next_index = '0;

  logic         pin_queue[$];
  chan_result_t expected_channels[$];
  int unsigned  items_queued = 0;
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  bit           in_fire = 1'b0;
  bit           no_gaps = 1'b0;
  bit           hold_req = 1'b0;
  bit           hold_done = 1'b0;
  int unsigned  hold_left = 0;

  ppm_pulse_train_decoder #(.COUNTER_WIDTH(CNT_W)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pin_level      (in_pin_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void decode_tick(input logic level);
    logic             rising;
    logic             falling;
    logic [CNT_W-1:0] pulse_time;
    int               time_i;
    int               offset_i;
    int               gain_i;
    int               scaled;
    chan_result_t     res;
    rising     = level && !prev_level;
    falling    = !level && prev_level;
    pulse_time = tick_count;
    if (falling) begin
      tick_count = '0;
    end else if (tick_count != TICK_MAX) begin
      tick_count = tick_count + 1'b1;
    end
    prev_level = level;
    if (rising) begin
      if (pulse_time <= gap_set) begin
        if (next_index < chlim_set) begin
          time_i   = pulse_time;
          offset_i = offset_set;
          gain_i   = gain_set;
          // int division truncates toward zero
          scaled = gain_i * (time_i - offset_i) / SCALE_DIV;
          if (scaled > 32767) scaled = 32767;
          if (scaled < -32768) scaled = -32768;
          res.index = next_index;
          res.value = scaled[VALUE_W-1:0];
          expected_channels.push_back(res);
        end
        if (next_index != INDEX_MAX) next_index = next_index + 1'b1;
      end else begin
        next_index = '0;
      end
    end
  endfunction

  // sampling, checking and watchdog
  always @(posedge clk) begin : check_results
    chan_result_t want;
    in_fire = in_valid && in_ready;
    if (in_fire) decode_tick(in_pin_level);
    if (out_valid && out_ready) begin
      if (expected_channels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected channel item: index %0d value %0d", $time,
                 out_channel_index, out_channel_value);
      end else begin
        want = expected_channels.pop_front();
        if (out_channel_index !== want.index) begin
          mismatches++;
          $display("%0t: channel index: expected %0d, actual %0d", $time,
                   want.index, out_channel_index);
        end
        if (out_channel_value !== want.value) begin
          mismatches++;
          $display("%0t: channel value: expected %0d, actual %0d", $time,
                   want.value, out_channel_value);
        end
      end
    end
    if (in_fire || (out_valid && out_ready) || cfg_psel) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // pin sample driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pin_queue.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid     <= 1'b1;
        in_pin_level <= pin_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done && out_valid) begin
      out_ready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic check_reg(input ppmd_reg_t reg_id, input logic [CFG_DATA_W-1:0] want_word);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {reg_id, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== want_word) begin
      mismatches++;
      $display("%0t: register %s readback: expected %0d, actual %0d", $time,
               reg_id.name(), want_word, cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // write with random junk above the field, then read it back
  task automatic write_reg(input ppmd_reg_t reg_id, input logic [CFG_DATA_W-1:0] field);
    int unsigned           w;
    logic [CFG_DATA_W-1:0] masked;
    case (reg_id)
      REG_GAIN:   w = GAIN_W;
      REG_OFFSET: w = OFFSET_W;
      REG_GAP:    w = GAP_W;
      default:    w = INDEX_W;
    endcase
    masked = field & ((32'd1 << w) - 1);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_id, 2'b00};
    cfg_pwdata  <= masked | ({$urandom} << w);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (reg_id)
      REG_GAIN:   gain_set   = masked[GAIN_W-1:0];
      REG_OFFSET: offset_set = masked[OFFSET_W-1:0];
      REG_GAP:    gap_set    = masked[GAP_W-1:0];
      default:    chlim_set  = masked[INDEX_W-1:0];
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    check_reg(reg_id, masked);
  endtask

  task automatic set_all(input int unsigned gain, input int unsigned offset,
                         input int unsigned gap, input int unsigned chlim);
    write_reg(REG_GAIN, gain);
    write_reg(REG_OFFSET, offset);
    write_reg(REG_GAP, gap);
    write_reg(REG_CHLIM, chlim);
  endtask

  task automatic add_pulse(input int unsigned low_len, input int unsigned high_len);
    repeat (low_len) pin_queue.push_back(1'b0);
    repeat (high_len) pin_queue.push_back(1'b1);
    items_queued += low_len + high_len;
  endtask

  // wait until every sample is taken and every channel item is back
  task automatic wait_idle();
    while (pin_queue.size() != 0 || in_valid || expected_channels.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // frames of a sync gap and a run of channel pulses, with some line noise
  task automatic run_frames(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned span;
    int unsigned n_chan;
    span    = (gap_set > PULSE_CAP) ? PULSE_CAP : gap_set;
    stop_at = items_queued + n_items;
    while (items_queued < stop_at) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          pin_queue.push_back(1'($urandom_range(1)));
          items_queued++;
        end
      end else begin
        add_pulse(span + $urandom_range(2, 5), $urandom_range(1, 3));
        n_chan = $urandom_range(0, 17);
        repeat (n_chan) add_pulse($urandom_range(1, span + 1), $urandom_range(1, 3));
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    check_reg(REG_GAIN, GAIN_RESET);
    check_reg(REG_OFFSET, OFFSET_RESET);
    check_reg(REG_GAP, GAP_RESET);
    check_reg(REG_CHLIM, CHLIM_RESET);

    // first sample high counts as a rising edge on the count since reset
    add_pulse(0, 2);
    add_pulse(3, 1);
    add_pulse(1, 2);
    add_pulse(6, 1);
    wait_idle();

    // full negative clamp, index running up to the channel limit and sticking at 15
    set_all(1023, 4095, 65535, 15);
    repeat (17) add_pulse(1, 1);
    wait_idle();

    // all zero: nothing reported, anything longer than zero ticks is a sync
    set_all(0, 0, 0, 0);
    add_pulse(1, 1);
    add_pulse(3, 1);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_GAIN, $urandom_range(0, 1023));
      write_reg(REG_OFFSET, ($urandom_range(3) == 0) ? $urandom_range(0, 4095)
                                                      : $urandom_range(0, PULSE_CAP));
      write_reg(REG_GAP, $urandom_range(0, 30));
      write_reg(REG_CHLIM, $urandom_range(0, 15));
      no_gaps = (p == 2);
      if (p == 4) begin
        // dense results so the long hold-off backs up into the input
        write_reg(REG_GAP, 4);
        write_reg(REG_CHLIM, 15);
        hold_req = 1'b1;
      end
      run_frames(50);
      no_gaps = 1'b0;
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
